### rtl/soa_pkg.sv
`default_nettype none
package soa_pkg;

  // Fixed geometry: handle = {slot, object index}
  localparam int unsigned SLABS     = 16;
  localparam int unsigned OBJS      = 64;
  localparam int unsigned ORDER_MAX = 5;

  localparam int unsigned SW = 4;   // slot index bits
  localparam int unsigned OW = 6;   // object index bits
  localparam int unsigned HW = 10;  // handle bits
  localparam int unsigned CW = 5;   // list count bits, 0..SLABS

  // Operation codes
  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_FREE    = 2'd1;
  localparam logic [1:0] FN_RECLAIM = 2'd2;

  // Configuration register indexes
  localparam logic CFG_OBJS  = 1'b0;
  localparam logic CFG_ORDER = 1'b1;

  // Per-slot record held in the slab RAM
  typedef struct packed {
    logic [SW-1:0] nxt;
    logic [6:0]    inuse;
    logic [6:0]    fhead;
  } slab_ent_t;

  localparam int unsigned ENT_W = SW + 14;

endpackage
`default_nettype wire

### rtl/soa_ram.sv
`default_nettype none
module soa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/slab_object_allocator.sv
`default_nettype none
// Slab allocator for one object cache of 16 slab slots with up to 64 objects each.
// Each accepted beat yields one result beat. A free pushes the object back on
// its slab's free list; an allocation walks the list (up to 16 slabs) for a slab
// that is not full, else links a new slab and builds its free list; a reclaim
// walks the list and unlinks empty slabs. The list walk is bound by the
// registered read of the slab record RAM; the free-list build by the single
// write port of the object link RAM. No clearing pass after reset.
module slab_object_allocator (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [6:0]            cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_func,
  input  wire logic [9:0]            in_object_handle,
  input  wire logic signed [9:0]     in_reclaim_target,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [9:0]                 out_allocated_handle,
  output logic                       out_alloc_ok,
  output logic [8:0]                 out_pages_freed
);
  import soa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_FIND  = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_POPRD = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_FREE  = 4'd6;
  localparam logic [3:0] S_RECL  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [6:0]          opc_r;
  logic [2:0]          order_r;
  logic [1:0]          func_r, func_nxt;
  logic [HW-1:0]       handle_r, handle_nxt;
  logic signed [9:0]   target_r, target_nxt;
  logic [SW-1:0]       cur_r, cur_nxt, s_r, s_nxt, next_r, next_nxt, prev_r, prev_nxt;
  logic [CW-1:0]       i_r, i_nxt, steps_r, steps_nxt, count_r, count_nxt;
  logic [OW-1:0]       k_r, k_nxt;
  logic [6:0]          inuse_r, inuse_nxt, fh_r, fh_nxt;
  slab_ent_t           prev_ent_r, prev_ent_nxt;
  logic                at_head_r, at_head_nxt;
  logic [8:0]          pages_r, pages_nxt;
  logic [SW-1:0]       head_r, head_nxt;
  logic                nonempty_r, nonempty_nxt;
  logic [SLABS-1:0]    in_list_r, in_list_nxt;
  logic [HW-1:0]       res_h_r, res_h_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [HW-1:0]       out_h_r;
  logic                out_ok_r;
  logic [8:0]          out_p_r;

  // RAM ports
  logic                slab_we;
  logic [SW-1:0]       slab_waddr, slab_raddr;
  slab_ent_t           slab_wdata, slab_rd;
  logic [ENT_W-1:0]    slab_rdata;
  logic                obj_we;
  logic [HW-1:0]       obj_waddr, obj_raddr;
  logic [6:0]          obj_wdata, obj_rdata;

  // derived configuration
  logic [6:0]          cap;
  logic [2:0]          ord;
  logic [8:0]          per;
  logic                free_found;
  logic [SW-1:0]       free_slot;
  logic [8:0]          pages_new;
  logic [CW-1:0]       count_dec;
  logic                stop;

  assign slab_rd = slab_ent_t'(slab_rdata);

  soa_ram #(.WIDTH(ENT_W), .DEPTH(SLABS)) u_slab_ram (
    .clk(clk), .we(slab_we), .waddr(slab_waddr), .wdata(slab_wdata),
    .raddr(slab_raddr), .rdata(slab_rdata)
  );

  soa_ram #(.WIDTH(7), .DEPTH(SLABS * OBJS)) u_obj_ram (
    .clk(clk), .we(obj_we), .waddr(obj_waddr), .wdata(obj_wdata),
    .raddr(obj_raddr), .rdata(obj_rdata)
  );

  always_comb begin
    cap = (opc_r == 7'd0) ? 7'd1 : ((opc_r > 7'(OBJS)) ? 7'(OBJS) : opc_r);
    ord = (order_r > 3'(ORDER_MAX - 1)) ? 3'(ORDER_MAX - 1) : order_r;
    per = 9'd1 << ord;
  end

  // first slot not on the list
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int j = SLABS - 1; j >= 0; j--) begin
      if (!in_list_r[j]) begin
        free_found = 1'b1;
        free_slot  = SW'(j);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    handle_nxt    = handle_r;
    target_nxt    = target_r;
    cur_nxt       = cur_r;
    s_nxt         = s_r;
    next_nxt      = next_r;
    prev_nxt      = prev_r;
    i_nxt         = i_r;
    steps_nxt     = steps_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    inuse_nxt     = inuse_r;
    fh_nxt        = fh_r;
    prev_ent_nxt  = prev_ent_r;
    at_head_nxt   = at_head_r;
    pages_nxt     = pages_r;
    head_nxt      = head_r;
    nonempty_nxt  = nonempty_r;
    in_list_nxt   = in_list_r;
    res_h_nxt     = res_h_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    slab_we       = 1'b0;
    slab_waddr    = s_r;
    slab_wdata    = '{nxt: next_r, inuse: 7'(inuse_r + 7'd1), fhead: obj_rdata};
    slab_raddr    = cur_r;
    obj_we        = 1'b0;
    obj_waddr     = {s_r, k_r};
    obj_wdata     = '0;
    obj_raddr     = (state_r == S_SCAN) ? {cur_r, slab_rd.fhead[OW-1:0]}
                                        : {s_r, fh_r[OW-1:0]};
    pages_new     = pages_r;
    count_dec     = count_r - CW'(1);
    stop          = 1'b0;
    in_stall      = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          handle_nxt = in_object_handle;
          target_nxt = in_reclaim_target;
          i_nxt      = '0;
          at_head_nxt = 1'b1;
          pages_nxt  = '0;
          res_h_nxt  = '0;
          res_ok_nxt = 1'b0;
          steps_nxt  = count_r;
          cur_nxt    = head_r;
          slab_raddr = head_r;
          case (in_func)
            FN_ALLOC:   state_nxt = (count_r == '0) ? S_FIND : S_SCAN;
            FN_FREE: begin
              s_nxt      = in_object_handle[HW-1:OW];
              slab_raddr = in_object_handle[HW-1:OW];
              state_nxt  = in_list_r[in_object_handle[HW-1:OW]] ? S_FREE : S_DONE;
            end
            FN_RECLAIM: state_nxt = (count_r == '0) ? S_DONE : S_RECL;
            default:    state_nxt = S_DONE;
          endcase
        end
      end

      // walk the list for a slab that is not full
      S_SCAN: begin
        if (slab_rd.inuse < cap) begin
          s_nxt     = cur_r;
          next_nxt  = slab_rd.nxt;
          inuse_nxt = slab_rd.inuse;
          fh_nxt    = slab_rd.fhead;
          state_nxt = S_POP;
        end else if (i_r + CW'(1) < count_r) begin
          i_nxt      = i_r + CW'(1);
          cur_nxt    = slab_rd.nxt;
          slab_raddr = slab_rd.nxt;
        end else begin
          state_nxt = S_FIND;
        end
      end

      // link a fresh slot at the head
      S_FIND: begin
        if (!free_found) begin
          state_nxt = S_DONE;
        end else begin
          s_nxt        = free_slot;
          next_nxt     = nonempty_r ? head_r : '0;
          head_nxt     = free_slot;
          nonempty_nxt = 1'b1;
          in_list_nxt[free_slot] = 1'b1;
          count_nxt    = count_r + CW'(1);
          k_nxt        = '0;
          state_nxt    = S_INIT;
        end
      end

      // build free list 0..n-1, one link a cycle
      S_INIT: begin
        obj_we    = 1'b1;
        obj_wdata = ((7'(k_r) + 7'd1) < cap) ? 7'(k_r) + 7'd1 : 7'd0;
        if (7'(k_r) == cap - 7'd1) begin
          fh_nxt    = '0;
          inuse_nxt = '0;
          state_nxt = S_POPRD;
        end else begin
          k_nxt = k_r + OW'(1);
        end
      end

      S_POPRD: state_nxt = S_POP;

      // pop object, write back slab record
      S_POP: begin
        slab_we    = 1'b1;
        res_h_nxt  = {s_r, fh_r[OW-1:0]};
        res_ok_nxt = 1'b1;
        state_nxt  = S_DONE;
      end

      S_FREE: begin
        if (slab_rd.inuse != 7'd0 && {1'b0, handle_r[OW-1:0]} < cap) begin
          obj_we     = 1'b1;
          obj_waddr  = {s_r, handle_r[OW-1:0]};
          obj_wdata  = slab_rd.fhead;
          slab_we    = 1'b1;
          slab_wdata = '{nxt: slab_rd.nxt, inuse: 7'(slab_rd.inuse - 7'd1),
                         fhead: {1'b0, handle_r[OW-1:0]}};
        end
        state_nxt = S_DONE;
      end

      // unlink empty slabs while walking
      S_RECL: begin
        if (slab_rd.inuse == 7'd0) begin
          if (at_head_r) begin
            head_nxt = slab_rd.nxt;
          end else begin
            slab_we      = 1'b1;
            slab_waddr   = prev_r;
            slab_wdata   = '{nxt: slab_rd.nxt, inuse: prev_ent_r.inuse,
                             fhead: prev_ent_r.fhead};
            prev_ent_nxt.nxt = slab_rd.nxt;
          end
          in_list_nxt[cur_r] = 1'b0;
          count_nxt = count_dec;
          pages_new = pages_r + per;
        end else begin
          prev_nxt     = cur_r;
          prev_ent_nxt = slab_rd;
          at_head_nxt  = 1'b0;
        end
        pages_nxt = pages_new;
        stop = (target_r > 10'sd0) && ({1'b0, pages_new} >= 10'(target_r));
        if (!stop && (i_r + CW'(1) < steps_r)) begin
          i_nxt      = i_r + CW'(1);
          cur_nxt    = slab_rd.nxt;
          slab_raddr = slab_rd.nxt;
        end else begin
          nonempty_nxt = (count_nxt != '0);
          if (count_nxt == '0) head_nxt = '0;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      opc_r       <= 7'd64;
      order_r     <= 3'd0;
      head_r      <= '0;
      nonempty_r  <= 1'b0;
      count_r     <= '0;
      in_list_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      nonempty_r  <= nonempty_nxt;
      count_r     <= count_nxt;
      in_list_r   <= in_list_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_OBJS:  opc_r   <= cfg_wdata;
          CFG_ORDER: order_r <= cfg_wdata[2:0];
          default:   ;
        endcase
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    handle_r   <= handle_nxt;
    target_r   <= target_nxt;
    cur_r      <= cur_nxt;
    s_r        <= s_nxt;
    next_r     <= next_nxt;
    prev_r     <= prev_nxt;
    i_r        <= i_nxt;
    steps_r    <= steps_nxt;
    k_r        <= k_nxt;
    inuse_r    <= inuse_nxt;
    fh_r       <= fh_nxt;
    prev_ent_r <= prev_ent_nxt;
    at_head_r  <= at_head_nxt;
    pages_r    <= pages_nxt;
    res_h_r    <= res_h_nxt;
    res_ok_r   <= res_ok_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_h_r  <= res_h_r;
      out_ok_r <= res_ok_r;
      out_p_r  <= (func_r == FN_RECLAIM) ? pages_r : 9'd0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_allocated_handle = out_h_r;
  assign out_alloc_ok         = out_ok_r;
  assign out_pages_freed      = out_p_r;

  // linked-slot bookkeeping agrees with the valid bits
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_list_r) == 32'(count_r))
    else $error("list count disagrees with linked slots");

  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (nonempty_r == (count_r != '0)))
    else $error("nonempty flag out of step with count");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_ok_r && (out_p_r != 9'd0)))
    else $error("alloc and reclaim results mixed");

endmodule
`default_nettype wire

### sim/slab_object_allocator_tb.sv
`default_nettype none
module slab_object_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import soa_pkg::*;

  localparam logic [1:0] FN_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [9:0] handle;
    logic       ok;
    logic [8:0] pages;
  } alloc_res_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [9:0]        handle;
    logic signed [9:0] target;
    logic              typed;
    alloc_res_t        res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_OBJS;
  logic [6:0]        cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_func = FN_NOP;
  logic [9:0]        in_object_handle = '0;
  logic signed [9:0] in_reclaim_target = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [9:0]        out_allocated_handle;
  logic              out_alloc_ok;
  logic [8:0]        out_pages_freed;

  slab_object_allocator dut (.*);

  always #5 clk = ~clk;

  // shadow copy of the cache
  logic [6:0] objs_reg = 7'd64;
  logic [2:0] order_reg = 3'd0;
  logic       slot_linked [SLABS] = '{default: 1'b0};
  logic [3:0] slot_link [SLABS];
  logic [3:0] head = '0;
  logic       nonempty = 1'b0;
  int         linked_cnt = 0;
  logic [6:0] inuse [SLABS];
  logic [6:0] free_top [SLABS];
  logic [6:0] obj_link [SLABS*OBJS];

  alloc_res_t pending_res [$];
  logic [9:0] live_handles [$];
  int         errors = 0;
  bit         steady = 1'b0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_cnt = 0;
  int         idle_cnt = 0;

  function automatic int unsigned slab_cap();
    if (objs_reg < 1) return 1;
    if (objs_reg > OBJS) return OBJS;
    return objs_reg;
  endfunction

  function automatic alloc_res_t predict_cache(logic [1:0] f, logic [9:0] h,
                                               logic signed [9:0] t);
    alloc_res_t r;
    int unsigned n, cur, s, idx, pages, per, steps, prv, nx;
    bit found, at_head;
    r = '0;
    n = slab_cap();
    case (f)
      FN_ALLOC: begin
        found = 0;
        s = 0;
        cur = head;
        for (int i = 0; i < linked_cnt && i < SLABS; i++) begin
          if (inuse[cur] < n) begin
            s = cur;
            found = 1;
            break;
          end
          cur = slot_link[cur];
        end
        if (!found) begin
          for (int i = 0; i < SLABS; i++)
            if (!slot_linked[i]) begin
              s = i;
              found = 1;
              break;
            end
          if (found) begin
            for (int i = 0; i < n; i++)
              obj_link[s*OBJS+i] = (i + 1 < n) ? 7'(i + 1) : 7'd0;
            free_top[s] = '0;
            inuse[s] = '0;
            slot_link[s] = nonempty ? head : 4'd0;
            head = 4'(s);
            nonempty = 1'b1;
            slot_linked[s] = 1'b1;
            linked_cnt++;
          end
        end
        if (found) begin
          idx = free_top[s] % OBJS;
          free_top[s] = obj_link[s*OBJS+idx];
          inuse[s] = inuse[s] + 7'd1;
          r.handle = 10'(s * OBJS + idx);
          r.ok = 1'b1;
        end
      end
      FN_FREE: begin
        s = h[9:6];
        idx = h[5:0];
        if (slot_linked[s] && inuse[s] != 0 && idx < n) begin
          obj_link[s*OBJS+idx] = free_top[s];
          free_top[s] = 7'(idx);
          inuse[s] = inuse[s] - 7'd1;
        end
      end
      FN_RECLAIM: begin
        pages = 0;
        per = 1 << ((order_reg > ORDER_MAX - 1) ? ORDER_MAX - 1 : order_reg);
        steps = linked_cnt;
        cur = head;
        prv = 0;
        at_head = 1;
        for (int i = 0; i < steps && i < SLABS; i++) begin
          nx = slot_link[cur];
          if (inuse[cur] == 0) begin
            if (at_head) head = 4'(nx);
            else slot_link[prv] = 4'(nx);
            slot_linked[cur] = 1'b0;
            linked_cnt--;
            pages += per;
          end else begin
            prv = cur;
            at_head = 0;
          end
          if (t > 0 && pages >= int'(t)) break;
          cur = nx;
        end
        nonempty = (linked_cnt != 0);
        if (!nonempty) head = '0;
        r.pages = (pages > 511) ? 9'd511 : 9'(pages);
      end
      default: ;
    endcase
    return r;
  endfunction

  // one beat on the request side; the shadow is updated once it is taken
  task automatic send_beat(logic [1:0] f, logic [9:0] h, logic signed [9:0] t,
                           logic typed, alloc_res_t typed_res);
    alloc_res_t p;
    in_valid <= 1'b1;
    in_func <= f;
    in_object_handle <= h;
    in_reclaim_target <= t;
    do @(posedge clk); while (in_stall);
    p = predict_cache(f, h, t);
    pending_res.push_back(typed ? typed_res : p);
    if (f == FN_ALLOC && p.ok) live_handles.push_back(p.handle);
    if (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OBJS) objs_reg = val;
    else order_reg = val[2:0];
  endtask

  // random traffic, mostly alloc/free pairs on live handles
  task automatic random_phase(int beats, bit pressure);
    int done, r, k;
    logic [1:0] f;
    logic [9:0] h;
    logic signed [9:0] t;
    done = 0;
    while (done < beats) begin
      if (pressure && done == beats / 3) hold_req++;
      if (pressure && done == 2 * beats / 3) wait_results();
      r = $urandom_range(99);
      h = 10'($urandom);
      t = 10'($urandom);
      f = FN_NOP;
      done++;
      if (r < 45) begin
        f = FN_ALLOC;
      end else if (r < 75) begin
        f = FN_FREE;
        if (live_handles.size() != 0) begin
          k = $urandom_range(live_handles.size() - 1);
          h = live_handles[k];
          if ($urandom_range(19) != 0) live_handles.delete(k);
        end
      end else if (r < 83) begin
        f = FN_FREE;
      end else if (r < 95) begin
        f = FN_RECLAIM;
        if ($urandom_range(2) == 0) t = 10'(int'($urandom_range(8)) - 1);
      end
      send_beat(f, h, t, 1'b0, '0);
    end
  endtask

  // directed rows; typed results only where obvious from a fresh cache
  stim_row_t directed [19] = '{
    '{FN_RECLAIM, 10'd0,    10'sd0,   1'b1, '{10'd0, 1'b0, 9'd0}},
    '{FN_NOP,     10'h3FF,  -10'sd1,  1'b1, '{10'd0, 1'b0, 9'd0}},
    '{FN_FREE,    10'd0,    10'sd0,   1'b1, '{10'd0, 1'b0, 9'd0}},
    '{FN_ALLOC,   10'd0,    10'sd0,   1'b1, '{10'd0, 1'b1, 9'd0}},
    '{FN_ALLOC,   10'h3FF,  10'sd511, 1'b1, '{10'd1, 1'b1, 9'd0}},
    '{FN_FREE,    10'd1,    10'sd0,   1'b1, '{10'd0, 1'b0, 9'd0}},
    '{FN_FREE,    10'd1,    10'sd0,   1'b0, '0},
    '{FN_ALLOC,   10'd0,    10'sd0,   1'b0, '0},
    '{FN_ALLOC,   10'd0,    10'sd0,   1'b0, '0},
    '{FN_FREE,    10'h3FF,  10'sd0,   1'b1, '{10'd0, 1'b0, 9'd0}},
    '{FN_RECLAIM, 10'd0,    -10'sd1,  1'b1, '{10'd0, 1'b0, 9'd0}},
    '{FN_RECLAIM, 10'd0,    10'sd511, 1'b0, '0},
    '{FN_FREE,    10'd0,    10'sd0,   1'b0, '0},
    '{FN_FREE,    10'd1,    10'sd0,   1'b0, '0},
    '{FN_FREE,    10'd2,    10'sd0,   1'b0, '0},
    '{FN_FREE,    10'd1,    10'sd0,   1'b0, '0},
    '{FN_RECLAIM, 10'd0,    10'sd1,   1'b0, '0},
    '{FN_RECLAIM, 10'd0,    -10'sd512, 1'b0, '0},
    '{FN_ALLOC,   10'd0,    10'sd0,   1'b0, '0}
  };

  // request side
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_beat(directed[i].func, directed[i].handle, directed[i].target,
                directed[i].typed, directed[i].res);
    wait_results();
    live_handles.delete();
    write_reg(CFG_OBJS, 7'd1);
    write_reg(CFG_ORDER, 7'd4);
    random_phase(150, 1'b0);
    wait_results();
    write_reg(CFG_OBJS, 7'd3);
    write_reg(CFG_ORDER, 7'd7);
    steady = 1'b1;
    random_phase(150, 1'b1);
    steady = 1'b0;
    wait_results();
    write_reg(CFG_OBJS, 7'd0);
    write_reg(CFG_ORDER, 7'd2);
    random_phase(150, 1'b0);
    wait_results();
    write_reg(CFG_OBJS, 7'd127);
    write_reg(CFG_ORDER, 7'd3);
    random_phase(150, 1'b0);
    wait_results();
    write_reg(CFG_OBJS, 7'd5);
    write_reg(CFG_ORDER, 7'd1);
    random_phase(170, 1'b1);
    wait_results();
    write_reg(CFG_OBJS, 7'd64);
    write_reg(CFG_ORDER, 7'd0);
    random_phase(150, 1'b0);
    wait_results();
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // result side: check each beat, then decide the stall for the next cycle
  always @(posedge clk) begin
    alloc_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat handle=%0d ok=%0d pages=%0d", $time,
                 out_allocated_handle, out_alloc_ok, out_pages_freed);
      end else begin
        e = pending_res.pop_front();
        if (out_allocated_handle !== e.handle) begin
          errors++;
          $display("%0t: allocated_handle exp %0d got %0d", $time, e.handle,
                   out_allocated_handle);
        end
        if (out_alloc_ok !== e.ok) begin
          errors++;
          $display("%0t: alloc_ok exp %0d got %0d", $time, e.ok, out_alloc_ok);
        end
        if (out_pages_freed !== e.pages) begin
          errors++;
          $display("%0t: pages_freed exp %0d got %0d", $time, e.pages,
                   out_pages_freed);
        end
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cnt <= RX_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 27);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cnt <= 0;
    else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else
      idle_cnt <= idle_cnt + 1;
  end

endmodule
`default_nettype wire

### slab_object_allocator.f
rtl/soa_pkg.sv
rtl/soa_ram.sv
rtl/slab_object_allocator.sv
sim/slab_object_allocator_tb.sv
